// ===== hw/rtl/thlp_pkg.sv =====
`default_nettype none

package thlp_pkg;

  // Store geometry.
  localparam int TABLE_DEPTH = 1024;
  localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  // Field widths fixed by the interface.
  localparam int MODE_W   = 2;
  localparam int KEY_W    = 32;
  localparam int IDX_W    = 10;
  localparam int SLOT_W   = 10;
  localparam int STATUS_W = 2;
  localparam int SIZE_W   = 11;

  // One step of the remainder unit per dividend bit.
  localparam int DIV_CNT_W = $clog2(KEY_W);

  localparam int ENTRY_W = 3 * KEY_W + IDX_W;

  // Operation codes.
  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_MISS = 2'd2;

  typedef struct packed {
    logic [KEY_W-1:0] key_a;
    logic [KEY_W-1:0] key_b;
    logic [KEY_W-1:0] key_c;
    logic [IDX_W-1:0] index;
  } slot_entry_t;

  // Status of the remainder unit as seen by the sequencer.
  typedef struct packed {
    logic              done;
    logic [SIZE_W-1:0] rem;
  } mod_rsp_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_MOD,
    S_RD,
    S_CHK,
    S_CLR,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/thlp_req_if.sv =====
`default_nettype none

interface thlp_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [31:0] key_a;
  logic [31:0] key_b;
  logic [31:0] key_c;
  logic [9:0]  payload_index;

  modport source (output valid, mode, key_a, key_b, key_c, payload_index, input ready);
  modport sink   (input valid, mode, key_a, key_b, key_c, payload_index, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/thlp_rsp_if.sv =====
`default_nettype none

interface thlp_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [9:0] found_index;
  logic [9:0] slot;

  modport source (output valid, status, found_index, slot, input ready);
  modport sink   (input valid, status, found_index, slot, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/thlp_ram.sv =====
`default_nettype none

module thlp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/thlp_mod_unit.sv =====
`default_nettype none

// Restoring remainder, one dividend bit per cycle, most significant first.
module thlp_mod_unit import thlp_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [KEY_W-1:0]  dividend,
  input  wire logic [SIZE_W-1:0] divisor,
  output mod_rsp_t               rsp
);

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [KEY_W-1:0]     shreg;
  logic [SIZE_W-1:0]    divr;
  logic [SIZE_W-1:0]    rem;
  logic [SIZE_W-1:0]    rem_next;
  logic [SIZE_W:0]      trial;

  // The partial remainder stays below the divisor, so the trial value is
  // below twice the divisor and one subtract restores it.
  always_comb begin
    trial = {rem, shreg[KEY_W-1]};
    if (trial >= {1'b0, divr}) begin
      rem_next = SIZE_W'(trial - {1'b0, divr});
    end else begin
      rem_next = trial[SIZE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(KEY_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      divr  <= divisor;
      rem   <= '0;
    end else if (busy) begin
      shreg <= {shreg[KEY_W-2:0], 1'b0};
      rem   <= rem_next;
    end
  end

  assign rsp.done = done;
  assign rsp.rem  = rem;

endmodule

`default_nettype wire

// ===== hw/rtl/triple_hash_linear_probe_table_top.sv =====
// Insert and lookup: the bit-serial remainder unit reduces key_a modulo the active size to a
//   first slot, then each probed slot (1 up to the active size of them) is read and checked.
// Clear zeroes the slot store; a zero table size for insert or lookup, or the unused mode, answers without a probe.
// One operation at a time; the next transfer is taken as soon as the result is registered.
// Reset (rst, synchronous, active high) clears the size register, then a clearing pass
//   zeroes the slot store while the input side is held not ready.
`default_nettype none

module triple_hash_linear_probe_table_top import thlp_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_wr_en,
  input  wire logic [SIZE_W-1:0] cfg_wr_data,
  thlp_req_if.sink               req,
  thlp_rsp_if.source             rsp
);

  // Configuration. Sizes beyond the store depth saturate to the depth.
  logic [SIZE_W-1:0] table_size;
  logic [SIZE_W-1:0] act_size;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= '0;
    end else if (cfg_wr_en) begin
      table_size <= cfg_wr_data;
    end
  end

  assign act_size = (int'(table_size) > TABLE_DEPTH) ? SIZE_W'(TABLE_DEPTH) : table_size;

  // Sequencer state and the captured request.
  state_t             state;
  state_t             state_next;
  logic [SIZE_W-1:0]  n;
  logic [MODE_W-1:0]  op_mode;
  logic [KEY_W-1:0]   key_a;
  logic [KEY_W-1:0]   key_b;
  logic [KEY_W-1:0]   key_c;
  logic [IDX_W-1:0]   pay;
  logic [ADDR_W-1:0]  s;
  logic [SIZE_W-1:0]  j;
  logic [ADDR_W-1:0]  clr_addr;
  logic [STATUS_W-1:0] res_status;
  logic [IDX_W-1:0]   res_found;
  logic [SLOT_W-1:0]  res_slot;

  logic               accept;
  logic               is_probe_op;
  logic               clr_last;
  logic               probe_last;
  logic               probe_wrap;
  logic               hit;
  logic               out_load;

  // Memory and remainder unit connections.
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  slot_entry_t        ram_wdata;
  slot_entry_t        ram_rdata;
  logic               mod_start;
  mod_rsp_t           mod_rsp;

  thlp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (s),
    .rdata (ram_rdata)
  );

  thlp_mod_unit u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (req.key_a),
    .divisor  (act_size),
    .rsp      (mod_rsp)
  );

  assign accept      = req.valid && req.ready;
  assign is_probe_op = (req.mode == MODE_INSERT) || (req.mode == MODE_LOOKUP);
  assign clr_last    = (clr_addr == ADDR_W'(TABLE_DEPTH - 1));

  // The probe walk wraps at the end of the active range, and ends at a hit or after n slots.
  assign probe_wrap = ((SIZE_W + 1)'(s) + 1'b1) == {1'b0, n};
  assign probe_last = ({1'b0, j} + 1'b1) == {1'b0, n};

  // An insert looks for an empty slot, a lookup for all three keys equal. A slot whose
  // keys are all zero is empty, so a lookup of zero keys stops at the first empty slot.
  always_comb begin
    if (op_mode == MODE_INSERT) begin
      hit = (ram_rdata.key_a == '0) && (ram_rdata.key_b == '0) && (ram_rdata.key_c == '0);
    end else begin
      hit = (ram_rdata.key_a == key_a) && (ram_rdata.key_b == key_b) &&
            (ram_rdata.key_c == key_c);
    end
  end

  // The finished result moves to the output register once that register is free.
  assign out_load = (state == S_DONE) && (!rsp.valid || rsp.ready);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_INIT: begin
        if (clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          priority if (is_probe_op && (act_size != '0)) begin
            state_next = S_MOD;
          end else if (req.mode == MODE_CLEAR) begin
            state_next = S_CLR;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_MOD: begin
        if (mod_rsp.done) begin
          state_next = S_RD;
        end
      end
      S_RD: begin
        state_next = S_CHK;
      end
      S_CHK: begin
        if (hit || probe_last) begin
          state_next = S_DONE;
        end else begin
          state_next = S_RD;
        end
      end
      S_CLR: begin
        if (clr_last) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_INIT;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    req.ready = 1'b0;
    mod_start = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = clr_addr;
    ram_wdata = '0;
    unique case (state)
      S_INIT, S_CLR: begin
        ram_we = 1'b1;
      end
      S_IDLE: begin
        req.ready = 1'b1;
        mod_start = req.valid && is_probe_op && (act_size != '0);
      end
      S_CHK: begin
        ram_waddr = s;
        ram_we    = (op_mode == MODE_INSERT) && hit;
        ram_wdata = '{key_a: key_a, key_b: key_b, key_c: key_c, index: pay};
      end
      S_MOD, S_RD, S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_INIT;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if ((state == S_INIT) || (state == S_CLR)) begin
        clr_addr <= clr_last ? '0 : clr_addr + 1'b1;
      end
    end
  end

  // Request capture, probe position and the pending result.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_mode    <= req.mode;
      key_a      <= req.key_a;
      key_b      <= req.key_b;
      key_c      <= req.key_c;
      pay        <= req.payload_index;
      n          <= act_size;
      res_found  <= '0;
      res_slot   <= '0;
      if ((act_size == '0) && (req.mode == MODE_INSERT)) begin
        res_status <= STAT_FULL;
      end else if ((act_size == '0) && (req.mode == MODE_LOOKUP)) begin
        res_status <= STAT_MISS;
      end else begin
        res_status <= STAT_OK;
      end
    end
    if ((state == S_MOD) && mod_rsp.done) begin
      s <= ADDR_W'(mod_rsp.rem);
      j <= '0;
    end
    if (state == S_CHK) begin
      if (hit) begin
        res_status <= STAT_OK;
        res_slot   <= SLOT_W'(s);
        res_found  <= (op_mode == MODE_LOOKUP) ? ram_rdata.index : '0;
      end else begin
        j <= j + 1'b1;
        s <= probe_wrap ? '0 : s + 1'b1;
        if (probe_last) begin
          res_status <= (op_mode == MODE_INSERT) ? STAT_FULL : STAT_MISS;
        end
      end
    end
  end

  // Output register: holds a result until its transfer, independent of the input side.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (out_load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp.status      <= res_status;
      rsp.found_index <= res_found;
      rsp.slot        <= res_slot;
    end
  end

  // The store is never written while a new request may be taken.
  a_no_write_when_ready: assert property (@(posedge clk) disable iff (rst)
    req.ready |-> !ram_we)
    else $error("store written while the input side is ready");

  // The probe position and count stay inside the active range.
  a_probe_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHK) |-> (((SIZE_W + 1)'(s) < {1'b0, n}) && (j < n)))
    else $error("probe outside the active range");

  // A failed operation reports neither a slot nor an index.
  a_fail_is_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && (rsp.status != STAT_OK)) |-> ((rsp.slot == '0) && (rsp.found_index == '0)))
    else $error("failed operation carries a slot or an index");

  // After reset the clearing pass runs before any request is taken.
  a_sweep_after_reset: assert property (@(posedge clk)
    rst |=> (!req.ready && (clr_addr == '0)))
    else $error("request side ready before the clearing pass");

endmodule

`default_nettype wire
